@@ hdl/gbn_fr_pkg.sv @@
// Shared types and codes for the Go-Back-N sender with fast retransmit.
// No dependencies; imported by the controller, datapath and top level.
package gbn_fr_pkg;

  localparam int unsigned SEQ_W = 4;   // sequence numbers mod 16
  localparam int unsigned LEN_W = 8;
  localparam int unsigned CFG_W = 4;
  localparam int unsigned CNT_W = 4;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 4'd4;
  localparam logic [CFG_W-1:0] DUP_THR_RESET = 4'd3;

  typedef enum logic [1:0] {
    KIND_OFFER   = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ACT_SENT     = 3'd0,
    ACT_RESENT   = 3'd1,
    ACT_REFUSED  = 3'd2,
    ACT_ACKED    = 3'd3,
    ACT_DUP      = 3'd4,
    ACT_IGNORED  = 3'd5,
    ACT_NONE_OUT = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    TMR_NONE    = 2'd0,
    TMR_START   = 2'd1,
    TMR_STOP    = 2'd2,
    TMR_RESTART = 2'd3
  } timer_e;

  typedef enum logic {
    CFG_WINDOW  = 1'b0,
    CFG_DUP_THR = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EVAL  = 2'd1,
    ST_BURST = 2'd2
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture the input transaction
    logic eval;   // decide and apply, emit single result or open a burst
    logic step;   // emit one resend result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic burst_go;    // resend with packets outstanding
    logic burst_last;  // current burst slot is the final one
  } status_t;

endpackage

@@ hdl/gbn_fr_ctrl.sv @@
// Controller state machine of the Go-Back-N sender.
// Depends on gbn_fr_pkg; drives commands to gbn_fr_dp and reads its status.
module gbn_fr_ctrl
  import gbn_fr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = status_i.burst_go ? ST_BURST : ST_IDLE;
      end
      ST_BURST: begin
        cmd_o.step = 1'b1;
        if (status_i.burst_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A burst is only ever entered from evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BURST) && ($past(state_q) == ST_IDLE) |-> 1'b0)
    else $error("burst entered without evaluation");

  // Each load is followed by exactly one evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.eval)
    else $error("load not followed by evaluation");

  // No new transaction is taken while a burst is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> !cmd_o.load)
    else $error("load during burst");

endmodule

@@ hdl/gbn_fr_dp.sv @@
// Datapath of the Go-Back-N sender: window state, length store, result registers.
// Depends on gbn_fr_pkg; commanded by gbn_fr_ctrl.
module gbn_fr_dp
  import gbn_fr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  logic             cfg_we_i,
  input  logic             cfg_addr_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic [1:0]       kind_i,
  input  logic [LEN_W-1:0] msg_len_i,
  input  logic [SEQ_W-1:0] ack_seq_i,
  input  logic             ack_ok_i,
  output logic             strobe_o,
  output logic [2:0]       action_o,
  output logic [SEQ_W-1:0] seq_o,
  output logic [LEN_W-1:0] length_o,
  output logic [1:0]       timer_cmd_o,
  output logic             last_o
);

  // Configuration
  logic [CFG_W-1:0] win_q, thr_q;
  // Window state
  logic [SEQ_W-1:0] base_q, base_d;
  logic [SEQ_W-1:0] next_q, next_d;
  logic [CNT_W-1:0] dup_q, dup_d;
  // Captured transaction
  logic [1:0]       kind_q;
  logic [LEN_W-1:0] len_q;
  logic [SEQ_W-1:0] ack_q;
  logic             ok_q;
  // Burst walk and length store
  logic [SEQ_W-1:0] bseq_q, bseq_d;
  logic [LEN_W-1:0] slot_mem [2**SEQ_W];
  logic [LEN_W-1:0] rd_data_q;
  logic [SEQ_W-1:0] rd_addr;
  logic             mem_we;
  // Result registers
  logic             strobe_q, strobe_d;
  logic [2:0]       action_q, action_d;
  logic [SEQ_W-1:0] seq_q, seq_d;
  logic [LEN_W-1:0] length_q, length_d;
  logic [1:0]       timer_q, timer_d;
  logic             last_q, last_d;

  // Evaluation terms
  logic [SEQ_W-1:0] outstanding, ack_dist, ack_next;
  logic [CNT_W-1:0] dup_inc, thr_eff;
  logic             resend, burst_go;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WINDOW_RESET;
      thr_q <= DUP_THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_WINDOW:  win_q <= cfg_wdata_i;
        CFG_DUP_THR: thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      len_q  <= msg_len_i;
      ack_q  <= ack_seq_i;
      ok_q   <= ack_ok_i;
    end
  end

  assign outstanding = next_q - base_q;
  assign ack_dist    = ack_q - base_q;
  assign ack_next    = ack_q + SEQ_W'(1);
  assign dup_inc     = (dup_q == '1) ? dup_q : dup_q + CNT_W'(1);
  assign thr_eff     = (thr_q == '0) ? CNT_W'(1) : thr_q;

  // Decide whether this transaction triggers a resend
  always_comb begin
    resend = 1'b0;
    case (kind_e'(kind_q))
      KIND_ACK: begin
        if (ok_q && !(ack_dist < outstanding && ack_dist < win_q) &&
            ack_next == base_q && dup_inc >= thr_eff) begin
          resend = 1'b1;
        end
      end
      KIND_TIMEOUT: resend = 1'b1;
      default: ;
    endcase
  end

  assign burst_go            = resend && (outstanding != '0);
  assign status_o.burst_go   = burst_go;
  assign status_o.burst_last = (bseq_q + SEQ_W'(1)) == next_q;

  // Evaluate, update window state and build the next result
  always_comb begin
    base_d   = base_q;
    next_d   = next_q;
    dup_d    = dup_q;
    bseq_d   = bseq_q;
    mem_we   = 1'b0;
    strobe_d = 1'b0;
    action_d = action_q;
    seq_d    = seq_q;
    length_d = length_q;
    timer_d  = timer_q;
    last_d   = last_q;
    if (cmd_i.eval) begin
      strobe_d = !burst_go;
      action_d = ACT_IGNORED;
      seq_d    = ack_q;
      length_d = '0;
      timer_d  = TMR_NONE;
      last_d   = 1'b1;
      bseq_d   = base_q;
      case (kind_e'(kind_q))
        KIND_OFFER: begin
          seq_d = next_q;
          if (len_q == '0 || outstanding >= win_q) begin
            action_d = ACT_REFUSED;
          end else begin
            mem_we   = 1'b1;
            action_d = ACT_SENT;
            length_d = len_q;
            timer_d  = (outstanding == '0) ? TMR_START : TMR_NONE;
            next_d   = next_q + SEQ_W'(1);
          end
        end
        KIND_ACK: begin
          if (ok_q && ack_dist < outstanding && ack_dist < win_q) begin
            base_d   = ack_next;
            dup_d    = '0;
            action_d = ACT_ACKED;
            timer_d  = (ack_next == next_q) ? TMR_STOP : TMR_NONE;
          end else if (ok_q && ack_next == base_q) begin
            if (dup_inc >= thr_eff) begin
              dup_d = '0;
            end else begin
              dup_d    = dup_inc;
              action_d = ACT_DUP;
            end
          end
        end
        KIND_TIMEOUT: ;
        default: seq_d = '0;
      endcase
      // Resend with nothing outstanding reports the empty window
      if (resend && !burst_go) begin
        action_d = ACT_NONE_OUT;
        seq_d    = base_q;
      end
    end else if (cmd_i.step) begin
      strobe_d = 1'b1;
      action_d = ACT_RESENT;
      seq_d    = bseq_q;
      length_d = rd_data_q;
      timer_d  = (bseq_q == base_q) ? TMR_RESTART : TMR_NONE;
      last_d   = status_o.burst_last;
      bseq_d   = bseq_q + SEQ_W'(1);
    end
  end

  // Window state and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      next_q   <= '0;
      dup_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      base_q   <= base_d;
      next_q   <= next_d;
      dup_q    <= dup_d;
      strobe_q <= strobe_d;
    end
  end

  // Result payload and burst pointer
  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    seq_q    <= seq_d;
    length_q <= length_d;
    timer_q  <= timer_d;
    last_q   <= last_d;
    bseq_q   <= bseq_d;
  end

  // Length store: registered read that prefetches the next burst slot
  assign rd_addr = cmd_i.eval ? base_q : bseq_q + SEQ_W'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[next_q] <= len_q;
    end
    rd_data_q <= slot_mem[rd_addr];
  end

  assign strobe_o    = strobe_q;
  assign action_o    = action_q;
  assign seq_o       = seq_q;
  assign length_o    = length_q;
  assign timer_cmd_o = timer_q;
  assign last_o      = last_q;

  // A result that is not the last is always followed by a burst step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && !last_q |-> cmd_i.step)
    else $error("burst broken off before its last result");

  // The first resend of a burst is the window base
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && action_q == ACT_RESENT && timer_q == TMR_RESTART |-> seq_q == base_q)
    else $error("burst did not start at window base");

  // A new packet is sent under the sequence number just before next_seq
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && action_q == ACT_SENT |-> (seq_q + SEQ_W'(1)) == next_q)
    else $error("sent sequence number out of step");

  // Burst steps only run with packets outstanding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> outstanding != '0)
    else $error("burst step with empty window");

endmodule

@@ hdl/go_back_n_sender_fast_retransmit.sv @@
// Go-Back-N sender with fast retransmit, sequence numbers mod 16.
// A single result is registered from the evaluation state; a resend burst starts after
// evaluation, once the length store read is registered, and sends one packet per cycle.
// A new transaction is accepted only in idle, after the previous result or burst is done.
// Reset: window base, next sequence and duplicate count clear; window 4, threshold 3.
// Results carry a one-cycle strobe; the receiver cannot stall.
module go_back_n_sender_fast_retransmit
  import gbn_fr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             cfg_we_i,
  input  logic             cfg_addr_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic [1:0]       kind_i,
  input  logic [LEN_W-1:0] msg_len_i,
  input  logic [SEQ_W-1:0] ack_seq_i,
  input  logic             ack_ok_i,
  output logic             res_strobe_o,
  output logic [2:0]       action_o,
  output logic [SEQ_W-1:0] seq_o,
  output logic [LEN_W-1:0] length_o,
  output logic [1:0]       timer_cmd_o,
  output logic             last_o
);

  cmd_t    cmd;
  status_t status;

  gbn_fr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  gbn_fr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .kind_i      (kind_i),
    .msg_len_i   (msg_len_i),
    .ack_seq_i   (ack_seq_i),
    .ack_ok_i    (ack_ok_i),
    .strobe_o    (res_strobe_o),
    .action_o    (action_o),
    .seq_o       (seq_o),
    .length_o    (length_o),
    .timer_cmd_o (timer_cmd_o),
    .last_o      (last_o)
  );

endmodule

@@ bench/go_back_n_sender_fast_retransmit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the Go-Back-N sender with fast retransmit: directed and random
// transactions are scored against a behavioural predictor of window, dup count and length store.
// Depends on gbn_fr_pkg and go_back_n_sender_fast_retransmit.
module go_back_n_sender_fast_retransmit_tb;
  import gbn_fr_pkg::*;

  localparam int unsigned SEQ_SPACE = 16;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam longint unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    action_e          action;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] length;
    timer_e           tmr;
    logic             last;
  } sender_result_t;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             cfg_we_i = 1'b0;
  logic             cfg_addr_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic [1:0]       kind_i = '0;
  logic [LEN_W-1:0] msg_len_i = '0;
  logic [SEQ_W-1:0] ack_seq_i = '0;
  logic             ack_ok_i = 1'b0;
  logic             res_strobe_o;
  logic [2:0]       action_o;
  logic [SEQ_W-1:0] seq_o;
  logic [LEN_W-1:0] length_o;
  logic [1:0]       timer_cmd_o;
  logic             last_o;

  // Predicted sender state and register copies
  logic [SEQ_W-1:0] win_base;
  logic [SEQ_W-1:0] next_seq;
  logic [CNT_W-1:0] dup_count;
  logic [CFG_W-1:0] window_size;
  logic [CFG_W-1:0] dup_threshold;
  logic [LEN_W-1:0] slot_len [SEQ_SPACE];

  sender_result_t   awaited_results [$];
  int unsigned      fail_count = 0;
  int unsigned      idle_pct = 0;
  longint unsigned  cycle_count = 0;

  go_back_n_sender_fast_retransmit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .kind_i       (kind_i),
    .msg_len_i    (msg_len_i),
    .ack_seq_i    (ack_seq_i),
    .ack_ok_i     (ack_ok_i),
    .res_strobe_o (res_strobe_o),
    .action_o     (action_o),
    .seq_o        (seq_o),
    .length_o     (length_o),
    .timer_cmd_o  (timer_cmd_o),
    .last_o       (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("go_back_n_sender_fast_retransmit_tb failed");
      $finish;
    end
  end

  function automatic void push_result(action_e action, logic [SEQ_W-1:0] seq,
                                      logic [LEN_W-1:0] length, timer_e tmr, logic last);
    sender_result_t r;
    r.action = action;
    r.seq    = seq;
    r.length = length;
    r.tmr    = tmr;
    r.last   = last;
    awaited_results.push_back(r);
  endfunction

  // Resend every outstanding packet from the window base, or report an empty window
  function automatic void predict_resend_burst();
    logic [SEQ_W-1:0] n;
    logic [SEQ_W-1:0] s;
    n = next_seq - win_base;
    if (n == 0) begin
      push_result(ACT_NONE_OUT, win_base, '0, TMR_NONE, 1'b1);
    end else begin
      for (int i = 0; i < n; i++) begin
        s = win_base + SEQ_W'(i);
        push_result(ACT_RESENT, s, slot_len[s], (i == 0) ? TMR_RESTART : TMR_NONE,
                    (i + 1 == n));
      end
    end
  endfunction

  // Advance the predicted sender by one accepted transaction
  function automatic void predict_sender(kind_e kind, logic [LEN_W-1:0] len,
                                         logic [SEQ_W-1:0] ack, logic ok);
    logic [SEQ_W-1:0] outstanding;
    logic [SEQ_W-1:0] d;
    logic [CNT_W-1:0] thr;
    outstanding = next_seq - win_base;
    case (kind)
      KIND_OFFER: begin
        if (len == 0 || outstanding >= window_size) begin
          push_result(ACT_REFUSED, next_seq, '0, TMR_NONE, 1'b1);
        end else begin
          slot_len[next_seq] = len;
          push_result(ACT_SENT, next_seq, len, (outstanding == 0) ? TMR_START : TMR_NONE,
                      1'b1);
          next_seq = next_seq + 4'd1;
        end
      end
      KIND_ACK: begin
        d = ack - win_base;
        if (!ok) begin
          push_result(ACT_IGNORED, ack, '0, TMR_NONE, 1'b1);
        end else if (d < outstanding && d < window_size) begin
          win_base  = ack + 4'd1;
          dup_count = '0;
          push_result(ACT_ACKED, ack, '0, (win_base == next_seq) ? TMR_STOP : TMR_NONE, 1'b1);
        end else if (ack + 4'd1 == win_base) begin
          thr = (dup_threshold == 0) ? 4'd1 : dup_threshold;
          if (dup_count != 4'd15) dup_count = dup_count + 4'd1;
          if (dup_count >= thr) begin
            dup_count = '0;
            predict_resend_burst();
          end else begin
            push_result(ACT_DUP, ack, '0, TMR_NONE, 1'b1);
          end
        end else begin
          push_result(ACT_IGNORED, ack, '0, TMR_NONE, 1'b1);
        end
      end
      KIND_TIMEOUT: predict_resend_burst();
      default: push_result(ACT_IGNORED, '0, '0, TMR_NONE, 1'b1);
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Score each result strobe against the oldest awaited result
  always @(posedge clk_i) begin : result_check
    sender_result_t want;
    if (rst_ni && res_strobe_o) begin
      if (awaited_results.size() == 0) begin
        fail_count++;
        $display("%0t: result not expected, expected none, actual action %0d seq %0d",
                 $time, action_o, seq_o);
      end else begin
        want = awaited_results.pop_front();
        check_field("action", 8'(want.action), 8'(action_o));
        check_field("seq", 8'(want.seq), 8'(seq_o));
        check_field("length", want.length, length_o);
        check_field("timer_cmd", 8'(want.tmr), 8'(timer_cmd_o));
        check_field("last", 8'(want.last), 8'(last_o));
      end
    end
  end

  // Offer one transaction after a random idle gap; start stays high on return
  task automatic send_item(input kind_e kind, input logic [LEN_W-1:0] len,
                           input logic [SEQ_W-1:0] ack, input logic ok);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    kind_i    <= kind;
    msg_len_i <= len;
    ack_seq_i <= ack;
    ack_ok_i  <= ok;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_sender(kind, len, ack, ok);
  endtask

  // Hold off until every awaited result has arrived, then let the block settle
  task automatic wait_results_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WINDOW) window_size = value;
    else dup_threshold = value;
    @(posedge clk_i);
  endtask

  // Reset window of 4: empty offer, fill the window, refuse once full
  task automatic test_offers_and_window();
    send_item(KIND_OFFER, 8'd0, 4'd0, 1'b0);
    send_item(KIND_OFFER, 8'd255, 4'd0, 1'b0);
    send_item(KIND_OFFER, 8'd1, 4'd0, 1'b0);
    send_item(KIND_OFFER, 8'h5A, 4'd0, 1'b0);
    send_item(KIND_OFFER, 8'hA5, 4'd0, 1'b0);
    send_item(KIND_OFFER, 8'h80, 4'd0, 1'b0);
  endtask

  // Corrupt, duplicate, out-of-window and good acknowledgements, and the unused kind
  task automatic test_ack_handling();
    send_item(KIND_ACK, 8'd0, 4'd2, 1'b0);
    send_item(KIND_ACK, 8'd0, 4'd15, 1'b1);
    send_item(KIND_ACK, 8'd0, 4'd15, 1'b1);
    send_item(KIND_ACK, 8'd0, 4'd9, 1'b1);
    send_item(KIND_ACK, 8'd0, 4'd1, 1'b1);
    send_item(KIND_ACK, 8'd0, 4'd1, 1'b1);
    send_item(KIND_UNUSED, 8'hFF, 4'd15, 1'b1);
  endtask

  // Fast retransmit, timeout bursts, emptying the window and resends with nothing out
  task automatic test_resend();
    send_item(KIND_ACK, 8'd0, 4'd1, 1'b1);
    send_item(KIND_ACK, 8'd0, 4'd1, 1'b1);
    send_item(KIND_TIMEOUT, 8'd0, 4'd0, 1'b0);
    send_item(KIND_ACK, 8'd0, 4'd3, 1'b1);
    send_item(KIND_TIMEOUT, 8'd0, 4'd0, 1'b0);
    send_item(KIND_ACK, 8'd0, 4'd3, 1'b1);
    wait_results_drained();
    write_register(CFG_WINDOW, 4'd15);
    write_register(CFG_DUP_THR, 4'd1);
    send_item(KIND_ACK, 8'd0, 4'd3, 1'b1);
  endtask

  // Mostly well-formed traffic steered by the predicted window, with some noise
  task automatic test_random_traffic(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] thr,
                                     input int unsigned idle, input int unsigned items);
    int unsigned      counted;
    int unsigned      pick;
    int unsigned      span;
    bit               held;
    kind_e            kind;
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] ack;
    logic [SEQ_W-1:0] outstanding;
    logic             ok;
    wait_results_drained();
    write_register(CFG_WINDOW, win);
    write_register(CFG_DUP_THR, thr);
    idle_pct = idle;
    counted  = 0;
    held     = 1'b0;
    while (counted < items) begin
      pick = $urandom_range(99);
      len  = LEN_W'($urandom_range(255, 1));
      ack  = SEQ_W'($urandom);
      ok   = 1'b1;
      if (pick < 40) begin
        kind = KIND_OFFER;
        if ($urandom_range(19) == 0) len = '0;
      end else if (pick < 88) begin
        kind = KIND_ACK;
        outstanding = next_seq - win_base;
        span = (outstanding < window_size) ? 32'(outstanding) : 32'(window_size);
        pick = $urandom_range(9);
        if (pick < 5 && span != 0) ack = win_base + SEQ_W'($urandom_range(span - 1));
        else if (pick < 8) ack = win_base - 4'd1;
        ok = ($urandom_range(9) != 0);
      end else if (pick < 97) begin
        kind = KIND_TIMEOUT;
      end else begin
        kind = KIND_UNUSED;
      end
      send_item(kind, len, ack, ok);
      if (kind != KIND_UNUSED && ok) counted++;
      // Pause mid-phase until the block has caught up
      if (!held && counted == items / 2) begin
        held = 1'b1;
        wait_results_drained();
      end
    end
  endtask

  initial begin
    win_base      = '0;
    next_seq      = '0;
    dup_count     = '0;
    window_size   = WINDOW_RESET;
    dup_threshold = DUP_THR_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_offers_and_window();
    test_ack_handling();
    test_resend();
    test_random_traffic(4'd15, 4'd1, 0, 48);
    test_random_traffic(4'd1, 4'd15, 49, 48);
    test_random_traffic(4'd8, 4'd2, 14, 48);
    test_random_traffic(4'd15, 4'd15, 0, 48);
    test_random_traffic(4'd1, 4'd1, 49, 48);
    test_random_traffic(CFG_W'($urandom_range(15, 1)), CFG_W'($urandom_range(15, 1)), 14, 50);

    wait_results_drained();
    if (fail_count == 0) begin
      $display("go_back_n_sender_fast_retransmit_tb passed");
    end else begin
      $display("go_back_n_sender_fast_retransmit_tb failed");
    end
    $finish;
  end

endmodule

@@ go_back_n_sender_fast_retransmit.f @@
hdl/gbn_fr_pkg.sv
hdl/gbn_fr_ctrl.sv
hdl/gbn_fr_dp.sv
hdl/go_back_n_sender_fast_retransmit.sv
bench/go_back_n_sender_fast_retransmit_tb.sv
